[design/mst_pkg.sv]
// Package for the minimum spanning tree block: sizes, codes, state and
// vertex cell control types. No dependencies.
package mst_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int WEIGHT_BITS  = 24;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int EADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
    localparam int KEY_W   = WEIGHT_BITS + 1;
    localparam int PAR_W   = VIDX_W + 1;
    localparam int EDGE_W  = 2 * VIDX_W + WEIGHT_BITS;
    localparam int CFG_W   = VCNT_W;

    // positive and above every weight, so any edge lowers an unreached key
    localparam logic signed [KEY_W-1:0] KEY_INF  = KEY_W'(1) << (WEIGHT_BITS - 1);
    localparam logic signed [PAR_W-1:0] PAR_NONE = '1;

    typedef enum logic {
        REG_VERTEX_COUNT = 1'b0,
        REG_START_VERTEX = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEARCH,
        ST_RELAX,
        ST_FINISH
    } state_t;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic                    found;
        logic signed [KEY_W-1:0] key;
        logic [VIDX_W-1:0]       idx;
        logic signed [PAR_W-1:0] par;
    } token_t;

    // broadcast control to every cell
    typedef struct packed {
        logic                    init;
        logic [VIDX_W-1:0]       start;
        logic [VCNT_W-1:0]       n;
        logic                    mark;
        logic [VIDX_W-1:0]       mark_idx;
        logic                    relax;
        logic [VIDX_W-1:0]       relax_other;
        logic signed [KEY_W-1:0] relax_w;
        logic [VIDX_W-1:0]       relax_par;
    } cell_ctl_t;

endpackage

[design/mst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[design/mst_cell.sv]
// One vertex cell: key, parent and visited flag, plus one stage of the
// minimum-search chain. Depends on mst_pkg.
module mst_cell (
    input  logic               aclk,
    input  logic [mst_pkg::VIDX_W-1:0] cell_idx,
    input  mst_pkg::cell_ctl_t ctl,
    input  mst_pkg::token_t    tok_in,
    output mst_pkg::token_t    tok_out
);
    import mst_pkg::*;

    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [PAR_W-1:0] par_reg, par_next;
    logic                    visited_reg, visited_next;
    token_t                  tok_reg, tok_next;
    logic                    elig;

    always_comb begin
        key_next     = key_reg;
        par_next     = par_reg;
        visited_next = visited_reg;
        if (ctl.init) begin
            key_next     = (cell_idx == ctl.start) ? '0 : KEY_INF;
            par_next     = PAR_NONE;
            visited_next = 1'b0;
        end else begin
            if (ctl.mark && ctl.mark_idx == cell_idx) begin
                visited_next = 1'b1;
            end
            if (ctl.relax && ctl.relax_other == cell_idx && !visited_reg
                    && ctl.relax_w < key_reg) begin
                key_next = ctl.relax_w;
                par_next = signed'({1'b0, ctl.relax_par});
            end
        end
    end

    // strict less keeps the earlier (lower) index on ties
    always_comb begin
        elig = !visited_reg && ({1'b0, cell_idx} < ctl.n);
        if (elig && (!tok_in.found || key_reg < tok_in.key)) begin
            tok_next.found = 1'b1;
            tok_next.key   = key_reg;
            tok_next.idx   = cell_idx;
            tok_next.par   = par_reg;
        end else begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        par_reg     <= par_next;
        visited_reg <= visited_next;
        tok_reg     <= tok_next;
    end

    assign tok_out = tok_reg;
endmodule

[design/minimum_spanning_tree_top.sv]
// Prim minimum spanning tree: edge loader, edge RAM, chain of vertex cells.
// Depends on mst_pkg, mst_ram, mst_cell.
//
// Edges are taken one per cycle while idle. After the last item the block
// runs Prim's algorithm and accepts no input until done. Each tree step lets
// the minimum ripple through the cell chain, then sweeps the edge RAM
// through its single read port for relaxation. A run stalls while a result
// waits to be taken. One result per extracted vertex other than the start,
// n - 1 in all.
module minimum_spanning_tree_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [mst_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_has_edge,
    input  logic [mst_pkg::VIDX_W-1:0]  s_edge_from,
    input  logic [mst_pkg::VIDX_W-1:0]  s_edge_to,
    input  logic signed [mst_pkg::WEIGHT_BITS-1:0] s_edge_weight,
    input  logic                        s_last_edge,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [mst_pkg::PAR_W-1:0] m_parent_vertex,
    output logic [mst_pkg::VIDX_W-1:0]  m_child_vertex,
    output logic                        m_final_res,
    output logic                        m_edges_dropped
);
    import mst_pkg::*;

    state_t              state_reg, state_next;
    logic [VCNT_W-1:0]   vcount_reg;
    logic [VIDX_W-1:0]   start_reg;
    logic [ECNT_W-1:0]   edge_cnt_reg, edge_cnt_next;
    logic                ovf_reg, ovf_next;
    logic [VCNT_W-1:0]   step_reg, step_next;
    logic [VCNT_W-1:0]   srch_cnt_reg, srch_cnt_next;
    logic [ECNT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                rd_pend_reg;
    logic [VIDX_W-1:0]   best_reg, best_next;

    logic                m_valid_reg, m_valid_next;
    logic signed [PAR_W-1:0] par_out_reg;
    logic [VIDX_W-1:0]   child_out_reg;
    logic                final_out_reg, drop_out_reg;

    logic [VCNT_W-1:0]   n_used;
    logic [VIDX_W-1:0]   s_used;
    logic                in_acc, edge_ok, ram_we, rd_issue;
    logic                srch_done, relax_done, emit;
    logic [EDGE_W-1:0]   ram_wdata, ram_rdata;
    logic [VIDX_W-1:0]   e_a, e_b;
    logic signed [KEY_W-1:0] e_w;
    cell_ctl_t           ctl;
    token_t              chain [MAX_VERTICES+1];

    always_comb begin
        if (vcount_reg == '0) begin
            n_used = VCNT_W'(1);
        end else if (vcount_reg > VCNT_W'(MAX_VERTICES)) begin
            n_used = VCNT_W'(MAX_VERTICES);
        end else begin
            n_used = vcount_reg;
        end
        s_used = ({1'b0, start_reg} < n_used) ? start_reg : VIDX_W'(n_used - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCNT_W'(MAX_VERTICES);
            start_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_VERTEX_COUNT: vcount_reg <= cfg_wdata[VCNT_W-1:0];
                REG_START_VERTEX: start_reg  <= cfg_wdata[VIDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign edge_ok = s_has_edge && ({1'b0, s_edge_from} < n_used)
                     && ({1'b0, s_edge_to} < n_used);
    assign ram_we    = in_acc && edge_ok && (edge_cnt_reg < ECNT_W'(MAX_EDGES));
    assign ram_wdata = {s_edge_from, s_edge_to, s_edge_weight};

    assign rd_issue   = (state_reg == ST_RELAX) && (rd_addr_reg < edge_cnt_reg);
    assign relax_done = (state_reg == ST_RELAX) && !rd_issue && !rd_pend_reg;
    assign srch_done  = (state_reg == ST_SEARCH)
                        && (srch_cnt_reg == VCNT_W'(MAX_VERTICES))
                        && (!m_valid_reg || m_ready);
    assign emit = srch_done && (chain[MAX_VERTICES].idx != s_used);

    mst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (edge_cnt_reg[EADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg[EADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign e_a = ram_rdata[EDGE_W-1 -: VIDX_W];
    assign e_b = ram_rdata[WEIGHT_BITS +: VIDX_W];
    assign e_w = KEY_W'(signed'(ram_rdata[WEIGHT_BITS-1:0]));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc && s_last_edge) state_next = ST_INIT;
            ST_INIT:   state_next = ST_SEARCH;
            ST_SEARCH: begin
                if (srch_done) begin
                    state_next = (step_reg + 1'b1 == n_used) ? ST_FINISH : ST_RELAX;
                end
            end
            ST_RELAX:  if (relax_done) state_next = ST_SEARCH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        edge_cnt_next = edge_cnt_reg;
        ovf_next      = ovf_reg;
        step_next     = step_reg;
        best_next     = best_reg;
        srch_cnt_next = '0;
        rd_addr_next  = '0;
        m_valid_next  = m_valid_reg && !m_ready;

        ctl             = '0;
        ctl.start       = s_used;
        ctl.n           = n_used;
        ctl.mark_idx    = chain[MAX_VERTICES].idx;
        ctl.relax_w     = e_w;
        ctl.relax_par   = best_reg;
        ctl.relax_other = (e_a == best_reg) ? e_b : e_a;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && edge_ok) begin
                    if (ram_we) edge_cnt_next = edge_cnt_reg + 1'b1;
                    else        ovf_next = 1'b1;
                end
            end
            ST_INIT: begin
                ctl.init  = 1'b1;
                step_next = '0;
            end
            ST_SEARCH: begin
                if (srch_cnt_reg != VCNT_W'(MAX_VERTICES)) begin
                    srch_cnt_next = srch_cnt_reg + 1'b1;
                end else begin
                    srch_cnt_next = srch_cnt_reg;
                end
                if (srch_done) begin
                    ctl.mark  = 1'b1;
                    best_next = chain[MAX_VERTICES].idx;
                    step_next = step_reg + 1'b1;
                    if (emit) m_valid_next = 1'b1;
                end
            end
            ST_RELAX: begin
                rd_addr_next = rd_issue ? rd_addr_reg + 1'b1 : rd_addr_reg;
                ctl.relax = rd_pend_reg && ({1'b0, e_a} < n_used)
                            && ({1'b0, e_b} < n_used)
                            && (e_a == best_reg || e_b == best_reg);
            end
            ST_FINISH: begin
                edge_cnt_next = '0;
                ovf_next      = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            edge_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            step_reg     <= '0;
            srch_cnt_reg <= '0;
            rd_addr_reg  <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            edge_cnt_reg <= edge_cnt_next;
            ovf_reg      <= ovf_next;
            step_reg     <= step_next;
            srch_cnt_reg <= srch_cnt_next;
            rd_addr_reg  <= rd_addr_next;
            rd_pend_reg  <= rd_issue;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        best_reg <= best_next;
        if (emit) begin
            par_out_reg   <= chain[MAX_VERTICES].par;
            child_out_reg <= chain[MAX_VERTICES].idx;
            final_out_reg <= (step_reg + 1'b1 == n_used);
            drop_out_reg  <= ovf_reg;
        end
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
        mst_cell u_cell (
            .aclk     (aclk),
            .cell_idx (VIDX_W'(i)),
            .ctl      (ctl),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    assign m_valid         = m_valid_reg;
    assign m_parent_vertex = par_out_reg;
    assign m_child_vertex  = child_out_reg;
    assign m_final_res     = final_out_reg;
    assign m_edges_dropped = drop_out_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        edge_cnt_reg <= ECNT_W'(MAX_EDGES))
        else $error("edge count above store size");
    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |=> edge_cnt_reg == '0 && !ovf_reg)
        else $error("edge count not cleared after run");
    a_no_root_out: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_child_vertex != s_used)
        else $error("start vertex emitted as a child");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !emit)
        else $error("result overwritten before taken");
`endif
endmodule

[tb/sv/minimum_spanning_tree_top_tb.sv]
// Testbench for minimum_spanning_tree_top: directed and random graphs through a queue-fed
// driver, Prim tree prediction per graph, and a scoreboard of tree edges.
// Depends on mst_pkg and the minimum_spanning_tree_top RTL.
module minimum_spanning_tree_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mst_pkg::*;

    typedef struct {
        logic                          has_edge;
        logic [VIDX_W-1:0]             from_v;
        logic [VIDX_W-1:0]             to_v;
        logic signed [WEIGHT_BITS-1:0] weight;
        logic                          last;
    } edge_req_t;

    typedef struct {
        logic signed [PAR_W-1:0] parent;
        logic [VIDX_W-1:0]       child;
        logic                    final_res;
        logic                    dropped;
    } tree_edge_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_has_edge = 1'b0;
    logic [VIDX_W-1:0] s_edge_from = '0;
    logic [VIDX_W-1:0] s_edge_to = '0;
    logic signed [WEIGHT_BITS-1:0] s_edge_weight = '0;
    logic s_last_edge = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [PAR_W-1:0] m_parent_vertex;
    logic [VIDX_W-1:0] m_child_vertex;
    logic m_final_res;
    logic m_edges_dropped;

    minimum_spanning_tree_top i_dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    int unsigned vcount_reg = 64;
    int unsigned start_reg = 0;
    int unsigned ecount;
    bit          overflow;
    int unsigned st_a[MAX_EDGES];
    int unsigned st_b[MAX_EDGES];
    int          st_w[MAX_EDGES];

    edge_req_t  pending_reqs[$];
    tree_edge_t expected_tree[$];
    int unsigned reqs_sent = 0;
    int unsigned reqs_queued = 0;
    bit failed = 0;
    bit hold_req = 0;
    bit stim_done = 0;
    int unsigned idle_cycles = 0;

    function automatic int unsigned vertices_in_use();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
        return vcount_reg;
    endfunction

    // loads one edge; on last, runs Prim and appends the tree edges
    function automatic void predict_tree(edge_req_t r);
        int unsigned n, s, best, other;
        longint key[MAX_VERTICES];
        int par[MAX_VERTICES];
        bit seen[MAX_VERTICES];
        int cnt;
        tree_edge_t t;
        n = vertices_in_use();
        cnt = 0;
        if (r.has_edge && r.from_v < n && r.to_v < n) begin
            if (ecount < MAX_EDGES) begin
                st_a[ecount] = 32'(r.from_v);
                st_b[ecount] = 32'(r.to_v);
                st_w[ecount] = 32'(r.weight);
                ecount++;
            end else begin
                overflow = 1;
            end
        end
        if (!r.last) return;
        s = (start_reg < n) ? start_reg : n - 1;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            key[i] = longint'(1) << WEIGHT_BITS;
            par[i] = -1;
            seen[i] = 0;
        end
        key[s] = 0;
        for (int step = 0; step < n; step++) begin
            best = n;
            for (int i = 0; i < n; i++)
                if (!seen[i] && (best == n || key[i] < key[best])) best = i;
            if (best >= n) break;
            seen[best] = 1;
            if (best != s) begin
                t.parent = PAR_W'(par[best]);
                t.child = VIDX_W'(best);
                t.final_res = 0;
                t.dropped = overflow;
                expected_tree = {expected_tree, t};
                cnt++;
            end
            for (int e = 0; e < ecount; e++) begin
                if (st_a[e] >= n || st_b[e] >= n) continue;
                if (st_a[e] == best) other = st_b[e];
                else if (st_b[e] == best) other = st_a[e];
                else continue;
                if (!seen[other] && st_w[e] < key[other]) begin
                    key[other] = longint'(st_w[e]);
                    par[other] = int'(best);
                end
            end
        end
        if (cnt > 0) expected_tree[$].final_res = 1;
        ecount = 0;
        overflow = 0;
    endfunction

    // handshakes seen at the rising edge, used by the falling-edge drivers
    bit s_taken = 0;
    bit m_taken = 0;
    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        m_taken <= m_valid && m_ready;
    end

    // driver
    int unsigned send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                s_valid <= 1'b0;
                send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
                if ($urandom_range(0, 2) == 0) send_gap = 0;
            end else if (!s_valid && pending_reqs.size() > 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    edge_req_t r;
                    r = pending_reqs.pop_front();
                    s_has_edge <= r.has_edge;
                    s_edge_from <= r.from_v;
                    s_edge_to <= r.to_v;
                    s_edge_weight <= r.weight;
                    s_last_edge <= r.last;
                    s_valid <= 1'b1;
                end
            end
        end
    end

    // receiver readiness; the one long hold is counted here
    int unsigned recv_gap = 0;
    int unsigned hold_cnt = 0;
    bit          hold_used = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req && !hold_used) begin
                hold_used = 1;
                hold_cnt = 3000;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (m_taken) begin
                recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
                m_ready <= (recv_gap == 0);
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= (recv_gap == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: inputs predicted at acceptance, results checked in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                edge_req_t r;
                r.has_edge = s_has_edge;
                r.from_v = s_edge_from;
                r.to_v = s_edge_to;
                r.weight = s_edge_weight;
                r.last = s_last_edge;
                predict_tree(r);
                reqs_sent++;
            end
            if (m_valid && m_ready) begin
                if (expected_tree.size() == 0) begin
                    $error("unexpected result parent=%0d child=%0d",
                           m_parent_vertex, m_child_vertex);
                    failed = 1;
                end else begin
                    tree_edge_t t;
                    t = expected_tree.pop_front();
                    if (m_parent_vertex !== t.parent) begin
                        $error("parent_vertex exp %0d got %0d", t.parent, m_parent_vertex);
                        failed = 1;
                    end
                    if (m_child_vertex !== t.child) begin
                        $error("child_vertex exp %0d got %0d", t.child, m_child_vertex);
                        failed = 1;
                    end
                    if (m_final_res !== t.final_res) begin
                        $error("final_res exp %0d got %0d", t.final_res, m_final_res);
                        failed = 1;
                    end
                    if (m_edges_dropped !== t.dropped) begin
                        $error("edges_dropped exp %0d got %0d", t.dropped, m_edges_dropped);
                        failed = 1;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no request or result accepted
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 60000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic edge_req_t make_edge(int unsigned f, int unsigned t, int w, bit last);
        edge_req_t r;
        r.has_edge = 1;
        r.from_v = VIDX_W'(f);
        r.to_v = VIDX_W'(t);
        r.weight = WEIGHT_BITS'(w);
        r.last = last;
        return r;
    endfunction

    function automatic void queue_req(edge_req_t r);
        pending_reqs = {pending_reqs, r};
        reqs_queued++;
    endfunction

    // random graph on n vertices with mostly valid endpoints
    function automatic void queue_graph(int unsigned n, int unsigned edges, bit narrow_w);
        edge_req_t r;
        for (int i = 0; i < edges; i++) begin
            r.has_edge = ($urandom_range(0, 15) != 0);
            if ($urandom_range(0, 9) == 0) begin
                r.from_v = VIDX_W'($urandom);
                r.to_v = VIDX_W'($urandom);
            end else begin
                r.from_v = VIDX_W'($urandom_range(0, n - 1));
                r.to_v = VIDX_W'($urandom_range(0, n - 1));
            end
            r.weight = narrow_w ? WEIGHT_BITS'(int'($urandom_range(0, 7)) - 3)
                                : WEIGHT_BITS'($urandom);
            r.last = (i == edges - 1);
            queue_req(r);
        end
    endfunction

    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && !s_valid && expected_tree.size() == 0);
        repeat (4 * MAX_VERTICES) @(posedge aclk);
    endtask

    task automatic write_cfg(cfg_reg_t idx, int unsigned val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_VERTEX_COUNT) vcount_reg = val;
        else start_reg = val;
    endtask

    initial begin
        int unsigned n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: small graph with extremes, self loop, ties, out of range
        write_cfg(REG_VERTEX_COUNT, 5);
        write_cfg(REG_START_VERTEX, 2);
        queue_req(make_edge(0, 1, 8388607, 0));
        queue_req(make_edge(1, 2, -8388608, 0));
        queue_req(make_edge(2, 2, -5, 0));
        queue_req(make_edge(3, 0, 4, 0));
        queue_req(make_edge(3, 1, 4, 0));
        queue_req(make_edge(63, 0, 1, 0));
        queue_req(make_edge(2, 3, 4, 1));
        wait_idle();
        // single vertex: no results; end-only marker
        write_cfg(REG_VERTEX_COUNT, 1);
        queue_req(make_edge(0, 0, 1, 0));
        begin
            edge_req_t r;
            r = make_edge(42, 21, -1, 1);
            r.has_edge = 0;
            queue_req(r);
        end
        wait_idle();
        // zero count, start clamped
        write_cfg(REG_VERTEX_COUNT, 0);
        write_cfg(REG_START_VERTEX, 63);
        queue_req(make_edge(0, 0, 0, 1));
        wait_idle();
        // full size, unreachable vertices, vertex count clamp from above 64
        write_cfg(REG_VERTEX_COUNT, 127);
        queue_req(make_edge(63, 62, -1, 0));
        queue_req(make_edge(62, 0, 3, 1));
        wait_idle();
        // store overflow: every edge valid so the store fills
        write_cfg(REG_VERTEX_COUNT, 8);
        write_cfg(REG_START_VERTEX, 0);
        for (int i = 0; i < MAX_EDGES + 4; i++)
            queue_req(make_edge($urandom_range(0, 7), $urandom_range(0, 7),
                                int'($urandom_range(0, 7)) - 3, i == MAX_EDGES + 3));
        wait_idle();

        // random graphs; one long receiver stall during the first
        for (int g = 0; reqs_queued < 290; g++) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(2, 12);
            write_cfg(REG_VERTEX_COUNT, n);
            write_cfg(REG_START_VERTEX, $urandom_range(0, 63));
            queue_graph(n, $urandom_range(1, 20), $urandom_range(0, 1));
            if (g == 0) begin
                repeat (5) queue_graph(n, 3, 1);
                hold_req = 1;
            end
            wait_idle();
        end
        stim_done = 1;
        if (!failed && expected_tree.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
